// ===== hw/rtl/ddgp_pkg.sv =====
// Shared types, constants and the digit cell table for the decimal digit glyph placer.
package ddgp_pkg;

   localparam int LINE_WIDTH_DEFAULT = 384;
   localparam int MAX_DIGITS_DEFAULT = 20;

   localparam int CFG_W      = 5;
   localparam int CSR_IDX_W  = 1;
   localparam int VALUE_W    = 32;
   localparam int MAG_W      = 31;
   localparam int PROD_W     = 63;
   localparam int QUOT_W     = 28;
   localparam int RECIP_SHIFT = 35;
   localparam int INDEX_W    = 17;
   localparam int MASK_W     = 15;
   localparam int DIGIT_W    = 4;
   localparam int MAX_GLYPHS = 21;
   localparam int MAX_STEP   = 124;

   localparam logic [31:0] RECIP_TEN = 32'hCCCC_CCCD;
   localparam logic [MAG_W-1:0] MAG_SAT = 31'h7FFF_FFFF;

   localparam int REQ_TDATA_W = 56;
   localparam int RSP_TDATA_W = 40;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SCALE      = 1'b0,
      CSR_MIN_DIGITS = 1'b1
   } csr_idx_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_SIGN,
      ST_RD,
      ST_EMIT
   } state_type;

   localparam logic GLYPH_DIGIT = 1'b0;
   localparam logic GLYPH_MINUS = 1'b1;

   // Controller to datapath
   typedef struct packed {
      logic load_req;
      logic do_mul;
      logic do_div;
      logic emit_sign;
      logic rd_issue;
      logic emit_digit;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic div_more;
      logic neg;
      logic cnt_zero;
      logic out_free;
   } stat_type;

   function automatic logic [MASK_W-1:0] digit_cells(input logic [DIGIT_W-1:0] k);
      logic [MASK_W-1:0] m;
      logic              mod3_one;
      mod3_one = (k == 4'd1) || (k == 4'd4) || (k == 4'd7) || (k == 4'd10)
              || (k == 4'd13);
      m = '0;
      m[0*3+0] = (k != 4'd1);
      m[1*3+0] = (k == 4'd0) || (k >= 4'd4);
      m[2*3+0] = (k != 4'd1);
      m[3*3+0] = (k[0] == 1'b0) && (k != 4'd4);
      m[4*3+0] = !mod3_one;
      m[0*3+1] = (k != 4'd1) && (k != 4'd4);
      m[2*3+1] = (k >= 4'd2) && (k != 4'd7);
      m[4*3+1] = !mod3_one;
      m[0*3+2] = 1'b1;
      m[1*3+2] = (k <= 4'd4) || (k >= 4'd7);
      m[2*3+2] = 1'b1;
      m[3*3+2] = (k != 4'd2);
      m[4*3+2] = 1'b1;
      return m;
   endfunction

endpackage

// ===== hw/rtl/ddgp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ddgp_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 20
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/ddgp_ctrl.sv =====
// Controller state machine: sequences load, digit conversion and glyph output.
module ddgp_ctrl
   import ddgp_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_MUL;
         end
         ST_MUL: state_in = ST_DIV;
         ST_DIV: begin
            if (stat.div_more)  state_in = ST_MUL;
            else if (stat.neg)  state_in = ST_SIGN;
            else                state_in = ST_RD;
         end
         ST_SIGN: begin
            if (stat.out_free) state_in = ST_RD;
         end
         ST_RD: state_in = ST_EMIT;
         ST_EMIT: begin
            if (stat.out_free && stat.cnt_zero) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready   = 1'b1;
            cmd.load_req = req_tvalid;
         end
         ST_MUL:  cmd.do_mul = 1'b1;
         ST_DIV:  cmd.do_div = 1'b1;
         ST_SIGN: cmd.emit_sign = stat.out_free;
         ST_RD:   cmd.rd_issue = 1'b1;
         ST_EMIT: begin
            cmd.emit_digit = stat.out_free;
            // prefetch the next digit while this one goes out
            cmd.rd_issue   = stat.out_free && !stat.cnt_zero;
         end
         default: cmd = '0;
      endcase
   end

endmodule

// ===== hw/rtl/ddgp_datapath.sv =====
// Datapath: magnitude, divide-by-ten step, digit store, position and output register.
module ddgp_datapath
   import ddgp_pkg::*;
#(
   parameter int LINE_WIDTH = LINE_WIDTH_DEFAULT,
   parameter int MAX_DIGITS = MAX_DIGITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   output stat_type               stat,
   input  logic [8:0]             pos_x,
   input  logic [7:0]             pos_y,
   input  logic [VALUE_W-1:0]     value,
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_addr,
   input  logic [CFG_W-1:0]       csr_wdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic                   glyph_kind,
   output logic [DIGIT_W-1:0]     digit,
   output logic [MASK_W-1:0]      cell_mask,
   output logic [INDEX_W-1:0]     pixel_index,
   output logic                   out_of_frame,
   output logic                   last
);

   localparam int CNT_W   = $clog2(MAX_DIGITS + 1);
   localparam int ADDR_W  = $clog2(MAX_DIGITS);
   localparam int POS_RAW = $clog2(511 + 255 * LINE_WIDTH + MAX_GLYPHS * MAX_STEP + 1);
   localparam int POS_W   = (POS_RAW > INDEX_W) ? POS_RAW : INDEX_W + 1;

   logic [CFG_W-1:0]  scale_ff, scale_in;
   logic [CFG_W-1:0]  min_digits_ff, min_digits_in;
   logic              neg_ff, neg_in;
   logic [MAG_W-1:0]  mag_ff, mag_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [POS_W-1:0]  pos_ff, pos_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               kind_ff, kind_in;
   logic [DIGIT_W-1:0] digit_ff, digit_in;
   logic [MASK_W-1:0]  mask_ff, mask_in;
   logic [INDEX_W-1:0] index_ff, index_in;
   logic               oof_ff, oof_in;
   logic               last_ff, last_in;

   logic [VALUE_W-1:0] mag_full;
   logic [MAG_W-1:0]   mag_load;
   logic [QUOT_W-1:0]  quot;
   logic [MAG_W-1:0]   quot10;
   logic [MAG_W-1:0]   rem_full;
   logic [CNT_W-1:0]   cnt_nx;
   logic [CNT_W-1:0]   cnt_dec;
   logic [CFG_W-1:0]   want;
   logic [POS_W-1:0]   step;
   logic [DIGIT_W-1:0] rd_digit;
   logic               out_free;

   always_comb begin
      mag_full = value[VALUE_W-1] ? (VALUE_W'(0) - value) : value;
      mag_load = mag_full[VALUE_W-1] ? MAG_SAT : mag_full[MAG_W-1:0];
      quot     = prod_ff[PROD_W-1:RECIP_SHIFT];
      quot10   = (MAG_W'(quot) << 3) + (MAG_W'(quot) << 1);
      rem_full = mag_ff - quot10;
      cnt_nx   = cnt_ff + CNT_W'(1);
      cnt_dec  = cnt_ff - CNT_W'(1);
      want     = (min_digits_ff > CFG_W'(MAX_DIGITS)) ? CFG_W'(MAX_DIGITS) : min_digits_ff;
      step     = POS_W'({scale_ff, 2'b00});
      out_free = !rsp_valid_ff || rsp_tready;
   end

   assign stat.div_more = ((quot != '0) || (CFG_W'(cnt_nx) < want))
                          && (cnt_nx < CNT_W'(MAX_DIGITS));
   assign stat.neg      = neg_ff;
   assign stat.cnt_zero = (cnt_ff == '0);
   assign stat.out_free = out_free;

   ddgp_ram #(
      .WIDTH(DIGIT_W),
      .DEPTH(MAX_DIGITS)
   ) u_digit_store (
      .clock  (clock),
      .wr_en  (cmd.do_div),
      .wr_addr(cnt_ff[ADDR_W-1:0]),
      .wr_data(rem_full[DIGIT_W-1:0]),
      .rd_en  (cmd.rd_issue),
      .rd_addr(cnt_dec[ADDR_W-1:0]),
      .rd_data(rd_digit)
   );

   always_comb begin
      scale_in      = scale_ff;
      min_digits_in = min_digits_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_SCALE:      scale_in      = csr_wdata;
            CSR_MIN_DIGITS: min_digits_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      neg_in  = neg_ff;
      mag_in  = mag_ff;
      prod_in = prod_ff;
      cnt_in  = cnt_ff;
      pos_in  = pos_ff;
      if (cmd.load_req) begin
         neg_in = value[VALUE_W-1];
         mag_in = mag_load;
         cnt_in = '0;
         pos_in = POS_W'(pos_x) + POS_W'(pos_y) * POS_W'(LINE_WIDTH);
      end
      if (cmd.do_mul) begin
         prod_in = PROD_W'(mag_ff) * PROD_W'(RECIP_TEN);
      end
      if (cmd.do_div) begin
         mag_in = MAG_W'(quot);
         cnt_in = cnt_nx;
      end
      if (cmd.rd_issue) begin
         cnt_in = cnt_dec;
      end
      if (cmd.emit_sign || cmd.emit_digit) begin
         pos_in = pos_ff + step;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      kind_in      = kind_ff;
      digit_in     = digit_ff;
      mask_in      = mask_ff;
      index_in     = index_ff;
      oof_in       = oof_ff;
      last_in      = last_ff;
      if (rsp_tready) rsp_valid_in = 1'b0;
      if (cmd.emit_sign) begin
         rsp_valid_in = 1'b1;
         kind_in      = GLYPH_MINUS;
         digit_in     = '0;
         mask_in      = '0;
         index_in     = pos_ff[INDEX_W-1:0];
         oof_in       = |pos_ff[POS_W-1:INDEX_W];
         last_in      = 1'b0;
      end else if (cmd.emit_digit) begin
         rsp_valid_in = 1'b1;
         kind_in      = GLYPH_DIGIT;
         digit_in     = rd_digit;
         mask_in      = digit_cells(rd_digit);
         index_in     = pos_ff[INDEX_W-1:0];
         oof_in       = |pos_ff[POS_W-1:INDEX_W];
         last_in      = (cnt_ff == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff      <= CFG_W'(1);
         min_digits_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         cnt_ff        <= '0;
         mag_ff        <= '0;
         pos_ff        <= '0;
         neg_ff        <= 1'b0;
      end else begin
         scale_ff      <= scale_in;
         min_digits_ff <= min_digits_in;
         rsp_valid_ff  <= rsp_valid_in;
         cnt_ff        <= cnt_in;
         mag_ff        <= mag_in;
         pos_ff        <= pos_in;
         neg_ff        <= neg_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      kind_ff  <= kind_in;
      digit_ff <= digit_in;
      mask_ff  <= mask_in;
      index_ff <= index_in;
      oof_ff   <= oof_in;
      last_ff  <= last_in;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign glyph_kind   = kind_ff;
   assign digit        = digit_ff;
   assign cell_mask    = mask_ff;
   assign pixel_index  = index_ff;
   assign out_of_frame = oof_ff;
   assign last         = last_ff;

endmodule

// ===== hw/rtl/decimal_digit_glyph_placer.sv =====
// Top level of the decimal digit glyph placer: stream ports, controller and datapath.
//
// One request (x, y, signed value) produces a minus bar glyph if the value is
// negative, then one 3x5 cell-mask digit glyph per decimal digit, most
// significant first, with tlast on the final digit; -2^31 renders as
// -2147483647 and min_digits pads with leading zeros. The request port takes
// one transaction at a time. Each digit is peeled off by a reciprocal multiply
// by ten: a multiply, then the remainder and digit store write. Glyphs then
// leave at one per cycle while the output is not held by back-pressure,
// behind one read of the digit store. The output register lets the last
// glyph wait while the next request is taken.
module decimal_digit_glyph_placer
   import ddgp_pkg::*;
#(
   parameter int LINE_WIDTH = LINE_WIDTH_DEFAULT,
   parameter int MAX_DIGITS = MAX_DIGITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // pos_x[8:0], pos_y[16:9], value[48:17]
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // digit[3:0], cell_mask[18:4],
                                               // pixel_index[35:19], out_of_frame[36]
   output logic                   rsp_tuser,   // glyph_kind
   output logic                   rsp_tlast,
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_addr,
   input  logic [CFG_W-1:0]       csr_wdata
);

   cmd_type            cmd;
   stat_type           stat;
   logic [DIGIT_W-1:0] digit;
   logic [MASK_W-1:0]  cell_mask;
   logic [INDEX_W-1:0] pixel_index;
   logic               out_of_frame;

   ddgp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ddgp_datapath #(
      .LINE_WIDTH(LINE_WIDTH),
      .MAX_DIGITS(MAX_DIGITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .pos_x       (req_tdata[8:0]),
      .pos_y       (req_tdata[16:9]),
      .value       (req_tdata[48:17]),
      .csr_we      (csr_we),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .glyph_kind  (rsp_tuser),
      .digit       (digit),
      .cell_mask   (cell_mask),
      .pixel_index (pixel_index),
      .out_of_frame(out_of_frame),
      .last        (rsp_tlast)
   );

   assign rsp_tdata = {3'b000, out_of_frame, pixel_index, cell_mask, digit};

endmodule
